// ===== sv/mrf_icm_label_update_assert.svh =====
`ifndef MRF_ICM_LABEL_UPDATE_ASSERT_SVH
`define MRF_ICM_LABEL_UPDATE_ASSERT_SVH

// A condition that must hold at every clock edge out of reset.
`define MRFICM_CHECK(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// A condition that must hold in the cycle after a trigger.
`define MRFICM_CHECK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/mrficm_pkg.sv =====
`timescale 1ns / 1ps

package mrficm_pkg;

    localparam logic [2:0] FUNC_WR_LABEL = 3'd0;
    localparam logic [2:0] FUNC_WR_NBR   = 3'd1;
    localparam logic [2:0] FUNC_WR_COUNT = 3'd2;
    localparam logic [2:0] FUNC_WR_LD    = 3'd3;
    localparam logic [2:0] FUNC_UPDATE   = 3'd4;
    localparam logic [2:0] FUNC_RD_LABEL = 3'd5;

    localparam logic CFG_NUM_CLASSES = 1'b0;
    localparam logic CFG_BETA        = 1'b1;

    typedef struct packed {
        logic load;
        logic do_write;
        logic lbl_rd;
        logic upd_start;
        logic cnt_latch;
        logic nb_issue;
        logic score_issue;
        logic wb;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [2:0] func;
        logic       ok;
        logic       walk_done;
        logic       pipe_busy;
        logic       score_done;
        logic       out_free;
    } ctrl_sts_t;

endpackage

// ===== sv/mrficm_ctrl.sv =====
`timescale 1ns / 1ps
`include "mrf_icm_label_update_assert.svh"

module mrficm_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  mrficm_pkg::ctrl_sts_t  sts,
    output mrficm_pkg::ctrl_cmd_t  cmd
);
    import mrficm_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_CNT,
        S_WALK,
        S_DRAIN,
        S_SCORE,
        S_WB,
        S_RESULT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_RESULT;
                unique case (sts.func) inside
                    FUNC_WR_LABEL, FUNC_WR_NBR, FUNC_WR_COUNT, FUNC_WR_LD:
                    begin
                        cmd.do_write = 1'b1;
                    end
                    FUNC_RD_LABEL:
                    begin
                        cmd.lbl_rd = sts.ok;
                    end
                    FUNC_UPDATE:
                    begin
                        if (sts.ok)
                        begin
                            cmd.upd_start = 1'b1;
                            state_next    = S_CNT;
                        end
                    end
                    default:
                    begin
                        state_next = S_RESULT;
                    end
                endcase
            end
            S_CNT:
            begin
                cmd.cnt_latch = 1'b1;
                state_next    = S_WALK;
            end
            S_WALK:
            begin
                if (sts.walk_done)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    cmd.nb_issue = 1'b1;
                end
            end
            S_DRAIN:
            begin
                if (!sts.pipe_busy)
                begin
                    state_next = S_SCORE;
                end
            end
            S_SCORE:
            begin
                // The compare of the last class resolves in the cycle that sees score_done.
                if (sts.score_done)
                begin
                    state_next = S_WB;
                end
                else
                begin
                    cmd.score_issue = 1'b1;
                end
            end
            S_WB:
            begin
                cmd.wb     = 1'b1;
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    `MRFICM_CHECK(a_out_load_free, !cmd.out_load || sts.out_free, "result loaded into a full output register")
    `MRFICM_CHECK(a_walk_bound, !cmd.nb_issue || !sts.walk_done, "neighbor read issued past the count")
    `MRFICM_CHECK(a_score_bound, !cmd.score_issue || !sts.score_done, "class scored past the class count")
    `MRFICM_CHECK_NEXT(a_one_item, in_valid && in_ready, !in_ready, "second request taken while busy")

endmodule

// ===== sv/mrficm_dp.sv =====
`timescale 1ns / 1ps

module mrficm_dp #(
    parameter int NUM_POINTS    = 1024,
    parameter int MAX_NEIGHBORS = 8,
    parameter int MAX_CLASSES   = 8
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic                   cfg_index,
    input  logic [16:0]            cfg_data,
    input  logic [2:0]             func,
    input  logic [9:0]             point,
    input  logic [2:0]             slot,
    input  logic [9:0]             value,
    input  logic signed [23:0]     log_density,
    input  mrficm_pkg::ctrl_cmd_t  cmd,
    output mrficm_pkg::ctrl_sts_t  sts,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [9:0]             point_out,
    output logic [2:0]             label_out,
    output logic signed [31:0]     best_score,
    output logic                   is_update
);
    import mrficm_pkg::*;

    localparam int PW    = $clog2(NUM_POINTS);
    localparam int NBAW  = $clog2(NUM_POINTS * MAX_NEIGHBORS);
    localparam int LDAW  = $clog2(NUM_POINTS * MAX_CLASSES);
    localparam int CW    = $clog2(MAX_CLASSES);
    localparam int LBL_W = (CW > 3) ? CW : 3;
    localparam int MW    = $clog2(MAX_NEIGHBORS + 1);
    localparam int JW    = $clog2(MAX_CLASSES + 1);
    localparam int VW    = MW;
    localparam int PRW   = 17 + VW + 1;
    localparam int SCW   = ((PRW > 24) ? PRW : 24) + 1;

    // Configuration
    logic [3:0]         num_classes_reg;
    logic signed [16:0] beta_reg;
    logic [JW-1:0]      k;

    // Captured request
    logic [2:0]         func_reg;
    logic [9:0]         point_reg;
    logic [2:0]         slot_reg;
    logic [9:0]         value_reg;
    logic signed [23:0] ld_wr_reg;
    logic               ok_reg;
    logic [NBAW-1:0]    nb_base_reg;
    logic [LDAW-1:0]    ld_base_reg;
    logic [PW-1:0]      pt_addr;

    // Memories
    logic [LBL_W-1:0]   label_mem [NUM_POINTS];
    logic [9:0]         nbr_mem   [NUM_POINTS * MAX_NEIGHBORS];
    logic [3:0]         count_mem [NUM_POINTS];
    logic signed [23:0] ld_mem    [NUM_POINTS * MAX_CLASSES];

    logic [LBL_W-1:0]   lbl_rdata_reg;
    logic [9:0]         nb_rdata_reg;
    logic [3:0]         cnt_rdata_reg;
    logic signed [23:0] ld_rdata_reg;

    // Neighbor walk and scoring
    logic [MW-1:0]      m_reg;
    logic [MW-1:0]      cnt_reg;
    logic [JW-1:0]      j_reg;
    logic               nb_v_reg;
    logic               lbl_v_reg;
    logic               sc_v_reg;
    logic [VW-1:0]      votes_reg [MAX_CLASSES];
    logic signed [PRW-1:0] prod_reg;
    logic signed [PRW-1:0] beta_ext;
    logic signed [PRW-1:0] vote_ext;
    logic [CW-1:0]      jd_reg;
    logic signed [SCW-1:0] score_sum;
    logic signed [SCW-1:0] best_reg;
    logic [CW-1:0]      best_lbl_reg;
    logic               nb_in_range;
    logic               vote_hit;
    logic               lbl_we;
    logic               lbl_re;
    logic [PW-1:0]      lbl_raddr;
    logic               out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_classes_reg <= 4'd2;
            beta_reg        <= 17'sd4096;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_NUM_CLASSES: num_classes_reg <= cfg_data[3:0];
                CFG_BETA:        beta_reg        <= $signed(cfg_data);
            endcase
        end
    end

    always_comb
    begin
        if (num_classes_reg == 4'd0)
        begin
            k = JW'(1);
        end
        else if (32'(num_classes_reg) > MAX_CLASSES)
        begin
            k = JW'(MAX_CLASSES);
        end
        else
        begin
            k = JW'(num_classes_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg    <= func;
            point_reg   <= point;
            slot_reg    <= slot;
            value_reg   <= value;
            ld_wr_reg   <= log_density;
            ok_reg      <= 32'(point) < NUM_POINTS;
            nb_base_reg <= NBAW'(32'(PW'(point)) * MAX_NEIGHBORS);
            ld_base_reg <= LDAW'(32'(PW'(point)) * MAX_CLASSES);
        end
    end

    assign pt_addr = PW'(point_reg);

    // Label store: request writes, update write-back, request reads and neighbor reads.
    assign nb_in_range = 32'(nb_rdata_reg) < NUM_POINTS;
    assign lbl_we = (cmd.do_write && func_reg == FUNC_WR_LABEL && ok_reg) || cmd.wb;
    assign lbl_re = cmd.lbl_rd || (nb_v_reg && nb_in_range);
    assign lbl_raddr = cmd.lbl_rd ? pt_addr : PW'(nb_rdata_reg);

    always_ff @(posedge clk)
    begin
        if (lbl_we)
        begin
            label_mem[pt_addr] <= cmd.wb ? LBL_W'(best_lbl_reg) : LBL_W'(value_reg[2:0]);
        end
        if (lbl_re)
        begin
            lbl_rdata_reg <= label_mem[lbl_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.do_write && func_reg == FUNC_WR_NBR && ok_reg
            && 32'(slot_reg) < MAX_NEIGHBORS)
        begin
            nbr_mem[nb_base_reg + NBAW'(slot_reg)] <= value_reg;
        end
        if (cmd.nb_issue)
        begin
            nb_rdata_reg <= nbr_mem[nb_base_reg + NBAW'(m_reg)];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.do_write && func_reg == FUNC_WR_COUNT && ok_reg)
        begin
            count_mem[pt_addr] <= value_reg[3:0];
        end
        if (cmd.upd_start)
        begin
            cnt_rdata_reg <= count_mem[pt_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.do_write && func_reg == FUNC_WR_LD && ok_reg
            && 32'(slot_reg) < MAX_CLASSES)
        begin
            ld_mem[ld_base_reg + LDAW'(slot_reg)] <= ld_wr_reg;
        end
        if (cmd.score_issue)
        begin
            ld_rdata_reg <= ld_mem[ld_base_reg + LDAW'(j_reg)];
        end
    end

    // Walk pipeline: neighbor read, then its label read, then the vote.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nb_v_reg  <= 1'b0;
            lbl_v_reg <= 1'b0;
            sc_v_reg  <= 1'b0;
            m_reg     <= '0;
            j_reg     <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            nb_v_reg  <= cmd.nb_issue;
            lbl_v_reg <= nb_v_reg && nb_in_range;
            sc_v_reg  <= cmd.score_issue;
            if (cmd.upd_start)
            begin
                m_reg <= '0;
                j_reg <= '0;
            end
            else
            begin
                if (cmd.nb_issue)
                begin
                    m_reg <= m_reg + MW'(1);
                end
                if (cmd.score_issue)
                begin
                    j_reg <= j_reg + JW'(1);
                end
            end
            if (cmd.cnt_latch)
            begin
                if (32'(cnt_rdata_reg) > MAX_NEIGHBORS)
                begin
                    cnt_reg <= MW'(MAX_NEIGHBORS);
                end
                else
                begin
                    cnt_reg <= MW'(cnt_rdata_reg);
                end
            end
        end
    end

    assign vote_hit = lbl_v_reg && (32'(lbl_rdata_reg) < 32'(k));

    always_ff @(posedge clk)
    begin
        if (cmd.upd_start)
        begin
            for (int i = 0; i < MAX_CLASSES; i++)
            begin
                votes_reg[i] <= '0;
            end
        end
        else if (vote_hit)
        begin
            votes_reg[lbl_rdata_reg[CW-1:0]] <= votes_reg[lbl_rdata_reg[CW-1:0]] + VW'(1);
        end
    end

    // Scoring: the product is formed while the log-density is read.
    assign beta_ext  = PRW'(beta_reg);
    assign vote_ext  = PRW'({1'b0, votes_reg[j_reg[CW-1:0]]});
    assign score_sum = SCW'(ld_rdata_reg) + SCW'(prod_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.score_issue)
        begin
            prod_reg <= beta_ext * vote_ext;
            jd_reg   <= j_reg[CW-1:0];
        end
        if (sc_v_reg && (jd_reg == '0 || score_sum > best_reg))
        begin
            best_reg     <= score_sum;
            best_lbl_reg <= jd_reg;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            point_out <= point_reg;
            is_update <= (func_reg == FUNC_UPDATE);
            if (func_reg == FUNC_UPDATE && ok_reg)
            begin
                label_out  <= 3'(best_lbl_reg);
                best_score <= 32'(best_reg);
            end
            else if (func_reg == FUNC_RD_LABEL && ok_reg)
            begin
                label_out  <= lbl_rdata_reg[2:0];
                best_score <= '0;
            end
            else
            begin
                label_out  <= '0;
                best_score <= '0;
            end
        end
    end

    assign out_valid = out_valid_reg;

    assign sts.func       = func_reg;
    assign sts.ok         = ok_reg;
    assign sts.walk_done  = (m_reg == cnt_reg);
    assign sts.pipe_busy  = nb_v_reg || lbl_v_reg;
    assign sts.score_done = (j_reg == k);
    assign sts.out_free   = !out_valid_reg || out_ready;

endmodule

// ===== sv/mrf_icm_label_update.sv =====
`timescale 1ns / 1ps
// One request at a time. A write, a read or an unused code goes from the execute state to the
// result state; an update also runs the count latch, neighbor walk, drain, scan and write-back.
// The update time is set by the neighbor walk (one memory read a cycle, three-stage pipeline)
// and by the class scan (one log-density read per class). The next request is taken in the
// cycle after the result enters the output register. Reset clears the controller and the output
// valid and sets the configuration registers (k = 2, beta = 1.0); the tables hold nothing until written.

module mrf_icm_label_update #(
    parameter int NUM_POINTS    = 1024,
    parameter int MAX_NEIGHBORS = 8,
    parameter int MAX_CLASSES   = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [16:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         func,
    input  logic [9:0]         point,
    input  logic [2:0]         slot,
    input  logic [9:0]         value,
    input  logic signed [23:0] log_density,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [9:0]         point_out,
    output logic [2:0]         label_out,
    output logic signed [31:0] best_score,
    output logic               is_update
);
    import mrficm_pkg::*;

    ctrl_cmd_t cmd;
    ctrl_sts_t sts;

    mrficm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    mrficm_dp #(
        .NUM_POINTS    (NUM_POINTS),
        .MAX_NEIGHBORS (MAX_NEIGHBORS),
        .MAX_CLASSES   (MAX_CLASSES)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .func        (func),
        .point       (point),
        .slot        (slot),
        .value       (value),
        .log_density (log_density),
        .cmd         (cmd),
        .sts         (sts),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .point_out   (point_out),
        .label_out   (label_out),
        .best_score  (best_score),
        .is_update   (is_update)
    );

endmodule
